// ----- hw/rtl/tbrl_pkg.sv -----
package tbrl_pkg;

    localparam int CFG_W     = 32;
    localparam int COUNT_W   = 32;
    localparam int WAIT_W    = 63;
    localparam int BAL_OUT_W = 48;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // request codes
    localparam logic [REQ_W-1:0] REQ_TIME  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TAKE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_AVAIL = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [IDX_W-1:0] CFG_QUANTUM  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CAPACITY = 2'd2;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_WAIT,
        STATUS_DEBT
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_KFIX,
        S_MUL,
        S_WCALC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic kfix;
        logic mul_step;
        logic wcalc;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic deficit;
        logic div_last;
        logic mul_last;
    } dp_sts_t;

endpackage

// ----- hw/rtl/tbrl_if.sv -----
interface tbrl_req_if;
    logic                          valid;
    logic                          ready;
    logic [tbrl_pkg::REQ_W-1:0]    req_type;
    logic [tbrl_pkg::COUNT_W-1:0]  count;
    logic [tbrl_pkg::WAIT_W-1:0]   max_wait;
    logic                          wait_unlimited;

    modport source (
        output valid, req_type, count, max_wait, wait_unlimited,
        input  ready
    );

    modport sink (
        input  valid, req_type, count, max_wait, wait_unlimited,
        output ready
    );
endinterface

interface tbrl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [tbrl_pkg::COUNT_W-1:0]   granted;
    logic [tbrl_pkg::WAIT_W-1:0]    wait_time;
    logic [tbrl_pkg::BAL_OUT_W-1:0] balance;

    modport source (
        output valid, status, granted, wait_time, balance,
        input  ready
    );

    modport sink (
        input  valid, status, granted, wait_time, balance,
        output ready
    );
endinterface

// ----- hw/rtl/tbrl_ctrl.sv -----
module tbrl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tbrl_pkg::dp_sts_t   sts,
    output tbrl_pkg::ctrl_cmd_t cmd
);

    tbrl_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbrl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            tbrl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = tbrl_pkg::S_EVAL;
                end
            end
            tbrl_pkg::S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.deficit ? tbrl_pkg::S_DIV : tbrl_pkg::S_DONE;
            end
            tbrl_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = tbrl_pkg::S_KFIX;
                end
            end
            tbrl_pkg::S_KFIX:
            begin
                cmd.kfix   = 1'b1;
                state_next = tbrl_pkg::S_MUL;
            end
            tbrl_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = tbrl_pkg::S_WCALC;
                end
            end
            tbrl_pkg::S_WCALC:
            begin
                cmd.wcalc  = 1'b1;
                state_next = tbrl_pkg::S_DONE;
            end
            tbrl_pkg::S_DONE:
            begin
                // hold until the output register is free or drains this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = tbrl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tbrl_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/tbrl_dp.sv -----
module tbrl_dp #(
    parameter int BALANCE_BITS = 49
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tbrl_pkg::IDX_W-1:0]        cfg_index,
    input  logic [tbrl_pkg::CFG_W-1:0]        cfg_data,
    input  logic [tbrl_pkg::REQ_W-1:0]        in_req_type,
    input  logic [tbrl_pkg::COUNT_W-1:0]      in_count,
    input  logic [tbrl_pkg::WAIT_W-1:0]       in_max_wait,
    input  logic                              in_wait_unlimited,
    input  tbrl_pkg::ctrl_cmd_t               cmd,
    output tbrl_pkg::dp_sts_t                 sts,
    output logic [1:0]                        out_status,
    output logic [tbrl_pkg::COUNT_W-1:0]      out_granted,
    output logic [tbrl_pkg::WAIT_W-1:0]       out_wait_time,
    output logic [tbrl_pkg::BAL_OUT_W-1:0]    out_balance
);

    localparam int BW = BALANCE_BITS;
    localparam int DW = BW - 1;
    localparam int PW = DW + tbrl_pkg::CFG_W;
    localparam int CW = $clog2(DW);
    localparam int XW = BW - tbrl_pkg::COUNT_W;

    // configuration and bucket state
    logic [tbrl_pkg::CFG_W-1:0] interval_reg, quantum_reg, capacity_reg;
    logic signed [BW-1:0]       balance_reg, balance_next;
    logic [tbrl_pkg::CFG_W-1:0] phase_reg, phase_next;

    // latched item
    logic [tbrl_pkg::REQ_W-1:0]   req_type_reg;
    logic [tbrl_pkg::COUNT_W-1:0] count_reg;
    logic [tbrl_pkg::WAIT_W-1:0]  max_wait_reg;
    logic                         unlimited_reg;

    // wait computation
    logic signed [BW-1:0]       nb_reg;
    logic                       deficit_reg;
    logic [DW-1:0]              quo_reg;
    logic [tbrl_pkg::CFG_W-1:0] rem_reg;
    logic [DW-1:0]              k_reg;
    logic [tbrl_pkg::CFG_W-1:0] mplier_reg;
    logic [PW-1:0]              prod_reg;
    logic [tbrl_pkg::WAIT_W-1:0] wait_reg;
    logic [CW-1:0]              iter_reg;

    // result register
    tbrl_pkg::status_t             status_reg;
    logic [tbrl_pkg::COUNT_W-1:0]  granted_reg;
    logic [tbrl_pkg::WAIT_W-1:0]   wait_time_reg;
    logic [tbrl_pkg::BAL_OUT_W-1:0] balance_out_reg;

    logic [tbrl_pkg::CFG_W-1:0] iv_eff, q_eff;
    logic signed [BW-1:0]       count_s, cap_s, quantum_s, grant_s;
    logic signed [BW-1:0]       diff, deficit_val, refill_sum, refilled;
    logic                       take_active;
    logic [tbrl_pkg::CFG_W:0]   trial;
    logic                       trial_ge;
    logic [tbrl_pkg::CFG_W-1:0] rem_step;
    logic [PW-1:0]              prod_step;
    logic [63:0]                wait_limit;
    logic [tbrl_pkg::WAIT_W-1:0] wait_calc;
    logic [tbrl_pkg::CFG_W:0]   phase_inc;
    logic                       wrap;
    logic [tbrl_pkg::COUNT_W-1:0] grant_val;
    logic                       wait_refuse, debt_refuse;
    tbrl_pkg::status_t          status_next;
    logic [tbrl_pkg::COUNT_W-1:0] granted_next;
    logic [tbrl_pkg::WAIT_W-1:0]  wait_time_next;
    logic [63:0]                bal_wide;

    assign iv_eff    = (interval_reg == '0) ? tbrl_pkg::CFG_W'(1) : interval_reg;
    assign q_eff     = (quantum_reg == '0) ? tbrl_pkg::CFG_W'(1) : quantum_reg;
    assign count_s   = signed'({{XW{1'b0}}, count_reg});
    assign cap_s     = signed'({{XW{1'b0}}, capacity_reg});
    assign quantum_s = signed'({{XW{1'b0}}, q_eff});

    assign take_active = (req_type_reg == tbrl_pkg::REQ_TAKE) && (count_reg != '0);
    assign diff        = balance_reg - count_s;
    assign deficit_val = count_s - balance_reg;

    assign sts.deficit  = take_active && (balance_reg < count_s);
    assign sts.div_last = (iter_reg == CW'(DW - 1));
    assign sts.mul_last = (iter_reg == CW'(tbrl_pkg::CFG_W - 1));

    // restoring division, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign trial_ge = (trial >= {1'b0, q_eff});
    assign rem_step = trial_ge ? tbrl_pkg::CFG_W'(trial - {1'b0, q_eff})
                               : trial[tbrl_pkg::CFG_W-1:0];

    // shift-add multiply, interval bits from the top
    assign prod_step = {prod_reg[PW-2:0], 1'b0}
                     + (mplier_reg[tbrl_pkg::CFG_W-1] ? PW'(k_reg) : '0);

    assign wait_limit = {1'b0, tbrl_pkg::WAIT_MAX} + {32'd0, phase_reg};

    always_comb
    begin
        if (prod_reg > PW'(wait_limit))
        begin
            wait_calc = tbrl_pkg::WAIT_MAX;
        end
        else if (prod_reg <= PW'(phase_reg))
        begin
            wait_calc = '0;
        end
        else
        begin
            wait_calc = tbrl_pkg::WAIT_W'(prod_reg - PW'(phase_reg));
        end
    end

    assign phase_inc  = {1'b0, phase_reg} + (tbrl_pkg::CFG_W + 1)'(1);
    assign wrap       = (phase_inc >= {1'b0, iv_eff});
    assign refill_sum = balance_reg + quantum_s;
    assign refilled   = (refill_sum > cap_s) ? cap_s : refill_sum;
    assign grant_val  = (count_s < balance_reg) ? count_reg
                                                : balance_reg[tbrl_pkg::COUNT_W-1:0];
    assign grant_s    = signed'({{XW{1'b0}}, grant_val});

    assign wait_refuse = !unlimited_reg && (wait_reg > max_wait_reg);
    // below the debt floor exactly when the top two bits read 10
    assign debt_refuse = nb_reg[BW-1] && !nb_reg[BW-2];

    always_comb
    begin
        balance_next   = balance_reg;
        phase_next     = phase_reg;
        status_next    = tbrl_pkg::STATUS_DONE;
        granted_next   = '0;
        wait_time_next = '0;
        case (req_type_reg)
            tbrl_pkg::REQ_TIME:
            begin
                if (wrap)
                begin
                    phase_next = '0;
                    if (balance_reg < cap_s)
                    begin
                        balance_next = refilled;
                    end
                end
                else
                begin
                    phase_next = phase_inc[tbrl_pkg::CFG_W-1:0];
                end
            end
            tbrl_pkg::REQ_TAKE:
            begin
                if (take_active)
                begin
                    if (!deficit_reg)
                    begin
                        balance_next = nb_reg;
                    end
                    else
                    begin
                        wait_time_next = wait_reg;
                        if (wait_refuse)
                        begin
                            status_next = tbrl_pkg::STATUS_WAIT;
                        end
                        else if (debt_refuse)
                        begin
                            status_next = tbrl_pkg::STATUS_DEBT;
                        end
                        else
                        begin
                            balance_next = nb_reg;
                        end
                    end
                end
            end
            tbrl_pkg::REQ_AVAIL:
            begin
                if ((count_reg != '0) && (balance_reg > 0))
                begin
                    granted_next = grant_val;
                    balance_next = balance_reg - grant_s;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign bal_wide = 64'(balance_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= tbrl_pkg::CFG_W'(1);
            quantum_reg  <= tbrl_pkg::CFG_W'(1);
            capacity_reg <= tbrl_pkg::CFG_W'(1);
            balance_reg  <= BW'(1);
            phase_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbrl_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                tbrl_pkg::CFG_QUANTUM:  quantum_reg  <= cfg_data;
                tbrl_pkg::CFG_CAPACITY:
                begin
                    capacity_reg <= cfg_data;
                    balance_reg  <= signed'({{XW{1'b0}}, cfg_data});
                    phase_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.commit)
        begin
            balance_reg <= balance_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_type_reg  <= in_req_type;
            count_reg     <= in_count;
            max_wait_reg  <= in_max_wait;
            unlimited_reg <= in_wait_unlimited;
        end
        if (cmd.eval)
        begin
            nb_reg      <= diff;
            deficit_reg <= sts.deficit;
            quo_reg     <= deficit_val[DW-1:0];
            rem_reg     <= '0;
            iter_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[DW-2:0], trial_ge};
            rem_reg  <= rem_step;
            iter_reg <= iter_reg + CW'(1);
        end
        if (cmd.kfix)
        begin
            // round the quotient up on a nonzero remainder
            k_reg      <= quo_reg + DW'(rem_reg != '0);
            mplier_reg <= iv_eff;
            prod_reg   <= '0;
            iter_reg   <= '0;
        end
        if (cmd.mul_step)
        begin
            prod_reg   <= prod_step;
            mplier_reg <= {mplier_reg[tbrl_pkg::CFG_W-2:0], 1'b0};
            iter_reg   <= iter_reg + CW'(1);
        end
        if (cmd.wcalc)
        begin
            wait_reg <= wait_calc;
        end
        if (cmd.commit)
        begin
            status_reg      <= status_next;
            granted_reg     <= granted_next;
            wait_time_reg   <= wait_time_next;
            balance_out_reg <= bal_wide[tbrl_pkg::BAL_OUT_W-1:0];
        end
    end

    assign out_status    = status_reg;
    assign out_granted   = granted_reg;
    assign out_wait_time = wait_time_reg;
    assign out_balance   = balance_out_reg;

endmodule

// ----- hw/rtl/token_bucket_rate_limiter.sv -----
// Time items, takes that stay out of debt and take-available items pass through the
// evaluate and done states. A take that goes into debt also passes through the
// restoring divider (one quotient bit per cycle) and the shift-add multiplier
// (one interval bit per cycle) before its result is valid.
// One item is worked on at a time.
// Reset: all three registers read 1, balance 1, phase 0; no clearing pass.
module token_bucket_rate_limiter #(
    parameter int BALANCE_BITS = 49
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tbrl_pkg::IDX_W-1:0] cfg_index,
    input  logic [tbrl_pkg::CFG_W-1:0] cfg_data,
    tbrl_req_if.sink                   req,
    tbrl_rsp_if.source                 rsp
);

    tbrl_pkg::ctrl_cmd_t cmd;
    tbrl_pkg::dp_sts_t   sts;

    tbrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tbrl_dp #(
        .BALANCE_BITS (BALANCE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_req_type       (req.req_type),
        .in_count          (req.count),
        .in_max_wait       (req.max_wait),
        .in_wait_unlimited (req.wait_unlimited),
        .cmd               (cmd),
        .sts               (sts),
        .out_status        (rsp.status),
        .out_granted       (rsp.granted),
        .out_wait_time     (rsp.wait_time),
        .out_balance       (rsp.balance)
    );

    // an accepted item keeps the input closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
    else $error("input accepted while an item is in flight");

    // a wait refusal always reports a nonzero wait and grants nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == tbrl_pkg::STATUS_WAIT))
            |-> ((rsp.wait_time != '0) && (rsp.granted == '0)))
    else $error("wait refusal with zero wait or a grant");

    // a grant only comes from a completed take-available item
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.granted != '0))
            |-> ((rsp.status == tbrl_pkg::STATUS_DONE) && (rsp.wait_time == '0)))
    else $error("grant reported with a refusal or a wait");

endmodule

// ----- tb/tb_token_bucket_rate_limiter.sv -----
module tb_token_bucket_rate_limiter;

    localparam int BAL_BITS     = 49;
    localparam int CLK_HALF     = 2;
    localparam int QUIET_CYCLES = BAL_BITS + 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1100;
    // full-size takes in the deep-debt walk; the floor itself lies far beyond the item budget
    localparam int DEBT_STEPS   = 8;

    localparam logic [tbrl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [tbrl_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [tbrl_pkg::REQ_W-1:0]   kind;
        logic [tbrl_pkg::COUNT_W-1:0] tokens;
        logic [tbrl_pkg::WAIT_W-1:0]  patience;
        logic                         unlimited;
    } bucket_request_t;

    typedef struct {
        tbrl_pkg::status_t              status;
        logic [tbrl_pkg::COUNT_W-1:0]   granted;
        logic [tbrl_pkg::WAIT_W-1:0]    wait_time;
        logic [tbrl_pkg::BAL_OUT_W-1:0] balance;
    } bucket_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [tbrl_pkg::IDX_W-1:0] cfg_index;
    logic [tbrl_pkg::CFG_W-1:0] cfg_data;

    tbrl_req_if req ();
    tbrl_rsp_if rsp ();

    token_bucket_rate_limiter #(
        .BALANCE_BITS(BAL_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    // shadow of the bucket
    logic [tbrl_pkg::CFG_W-1:0] interval_setting;
    logic [tbrl_pkg::CFG_W-1:0] quantum_setting;
    logic [tbrl_pkg::CFG_W-1:0] capacity_setting;
    logic signed [BAL_BITS-1:0] level;
    logic [tbrl_pkg::CFG_W-1:0] tick_phase;

    bucket_result_t bucket_results_due [$];

    bit          idling_on;
    int unsigned rsp_hold;
    int unsigned errors;
    int unsigned reg_writes;
    int unsigned results_checked;
    int unsigned wait_refusals;
    int unsigned debt_refusals;
    int unsigned grants;
    int unsigned kind_tally [4];

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(20, 4);
        return $urandom_range(150, 40);
    endfunction

    // ceil(deficit / quantum) * interval - phase, clipped to [0, WAIT_MAX]
    function automatic logic [tbrl_pkg::WAIT_W-1:0] refill_wait(input bit [63:0] deficit);
        bit [63:0] q;
        bit [63:0] iv;
        bit [63:0] k;
        bit [63:0] lim;
        bit [63:0] p;
        q   = (quantum_setting == 0) ? 64'd1 : 64'(quantum_setting);
        iv  = (interval_setting == 0) ? 64'd1 : 64'(interval_setting);
        k   = deficit / q + (((deficit % q) != 0) ? 64'd1 : 64'd0);
        lim = (64'(tbrl_pkg::WAIT_MAX) + 64'(tick_phase)) / iv;
        if (k > lim)
            return tbrl_pkg::WAIT_MAX;
        p = k * iv;
        if (p <= 64'(tick_phase))
            return '0;
        return tbrl_pkg::WAIT_W'(p - 64'(tick_phase));
    endfunction

    function automatic bucket_result_t bucket_step(input bucket_request_t it);
        bucket_result_t r;
        longint         lvl;
        longint         nb;
        longint         g;
        longint         cap;
        longint         floor_level;
        bit [63:0]      iv;
        r.status    = tbrl_pkg::STATUS_DONE;
        r.granted   = '0;
        r.wait_time = '0;
        lvl         = longint'(level);
        cap         = longint'(capacity_setting);
        floor_level = -(longint'(1) << (BAL_BITS - 2));
        iv          = (interval_setting == 0) ? 64'd1 : 64'(interval_setting);
        case (it.kind)
            tbrl_pkg::REQ_TIME:
            begin
                if (64'(tick_phase) + 64'd1 >= iv)
                begin
                    tick_phase = '0;
                    if (lvl < cap)
                    begin
                        lvl += (quantum_setting == 0) ? 64'sd1 : longint'(quantum_setting);
                        if (lvl > cap)
                            lvl = cap;
                    end
                end
                else
                begin
                    tick_phase = tick_phase + 1;
                end
            end
            tbrl_pkg::REQ_TAKE:
            begin
                if (it.tokens != 0)
                begin
                    nb = lvl - longint'(it.tokens);
                    if (nb >= 0)
                    begin
                        lvl = nb;
                    end
                    else
                    begin
                        r.wait_time = refill_wait(64'(-nb));
                        if (!it.unlimited && r.wait_time > it.patience)
                            r.status = tbrl_pkg::STATUS_WAIT;
                        else if (nb < floor_level)
                            r.status = tbrl_pkg::STATUS_DEBT;
                        else
                            lvl = nb;
                    end
                end
            end
            tbrl_pkg::REQ_AVAIL:
            begin
                if (it.tokens != 0 && lvl > 0)
                begin
                    g = (longint'(it.tokens) > lvl) ? lvl : longint'(it.tokens);
                    r.granted = tbrl_pkg::COUNT_W'(g);
                    lvl -= g;
                end
            end
            default:
            begin
            end
        endcase
        level     = BAL_BITS'(lvl);
        r.balance = tbrl_pkg::BAL_OUT_W'(lvl);
        return r;
    endfunction

    task automatic send_item(input logic [tbrl_pkg::REQ_W-1:0] kind,
                             input logic [tbrl_pkg::COUNT_W-1:0] tokens,
                             input logic [tbrl_pkg::WAIT_W-1:0] patience,
                             input logic unlimited);
        bucket_request_t item;
        int unsigned     gap;
        item.kind      = kind;
        item.tokens    = tokens;
        item.patience  = patience;
        item.unlimited = unlimited;
        gap = idling_on ? gap_length() : 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.req_type       <= kind;
        req.count          <= tokens;
        req.max_wait       <= patience;
        req.wait_unlimited <= unlimited;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        bucket_results_due.push_back(bucket_step(item));
        kind_tally[kind]++;
    endtask

    task automatic write_reg(input logic [tbrl_pkg::IDX_W-1:0] index,
                             input logic [tbrl_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            tbrl_pkg::CFG_INTERVAL: interval_setting = value;
            tbrl_pkg::CFG_QUANTUM:  quantum_setting  = value;
            tbrl_pkg::CFG_CAPACITY:
            begin
                capacity_setting = value;
                level            = {{(BAL_BITS - tbrl_pkg::CFG_W){1'b0}}, value};
                tick_phase       = '0;
            end
            default:
            begin
            end
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // hold the sender until every outstanding result is back
    task automatic hold_until_answered();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (bucket_results_due.size() != 0);
    endtask

    task automatic drain();
        hold_until_answered();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_item(tbrl_pkg::REQ_AVAIL, 32'd1, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TAKE, 32'd1, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TAKE, 32'd1, 63'd1, 1'b0);
        send_item(tbrl_pkg::REQ_AVAIL, 32'd3, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        // already at capacity: the wrap adds nothing
        send_item(tbrl_pkg::REQ_TIME, '1, tbrl_pkg::WAIT_MAX, 1'b1);
    endtask

    task automatic test_zero_and_unused();
        send_item(tbrl_pkg::REQ_TAKE, '0, '0, 1'b0);
        send_item(tbrl_pkg::REQ_AVAIL, '0, tbrl_pkg::WAIT_MAX, 1'b1);
        send_item(REQ_UNUSED, '1, tbrl_pkg::WAIT_MAX, 1'b1);
        send_item(REQ_UNUSED, '0, '0, 1'b0);
    endtask

    task automatic test_register_extremes();
        drain();
        write_reg(CFG_UNUSED, '1);
        write_reg(tbrl_pkg::CFG_INTERVAL, '0);
        write_reg(tbrl_pkg::CFG_QUANTUM, '0);
        write_reg(tbrl_pkg::CFG_CAPACITY, '1);
        send_item(tbrl_pkg::REQ_TAKE, '1, '0, 1'b0);
        send_item(tbrl_pkg::REQ_AVAIL, '1, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TAKE, '1, tbrl_pkg::WAIT_MAX, 1'b0);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        drain();
        write_reg(tbrl_pkg::CFG_INTERVAL, '1);
        write_reg(tbrl_pkg::CFG_QUANTUM, '1);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TAKE, '1, '0, 1'b1);
        send_item(tbrl_pkg::REQ_TAKE, '1, '0, 1'b1);
        drain();
        write_reg(tbrl_pkg::CFG_CAPACITY, '0);
        write_reg(tbrl_pkg::CFG_INTERVAL, 32'd1);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        send_item(tbrl_pkg::REQ_AVAIL, 32'd1, '0, 1'b0);
    endtask

    task automatic test_phase_past_interval();
        drain();
        write_reg(tbrl_pkg::CFG_INTERVAL, 32'd10);
        write_reg(tbrl_pkg::CFG_QUANTUM, 32'd1);
        write_reg(tbrl_pkg::CFG_CAPACITY, 32'd3);
        repeat (6) send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        drain();
        // phase is now past the new interval: the wait goes negative and clips
        write_reg(tbrl_pkg::CFG_INTERVAL, 32'd3);
        send_item(tbrl_pkg::REQ_TAKE, 32'd4, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
    endtask

    task automatic test_wait_saturation();
        drain();
        write_reg(tbrl_pkg::CFG_INTERVAL, '1);
        write_reg(tbrl_pkg::CFG_QUANTUM, 32'd1);
        write_reg(tbrl_pkg::CFG_CAPACITY, 32'd1);
        send_item(tbrl_pkg::REQ_TAKE, '1, '0, 1'b1);
        send_item(tbrl_pkg::REQ_TAKE, '1, tbrl_pkg::WAIT_MAX, 1'b0);
        send_item(tbrl_pkg::REQ_TAKE, 32'd1, tbrl_pkg::WAIT_MAX - 1, 1'b0);
    endtask

    task automatic test_deep_debt();
        int unsigned i;
        idling_on = 1'b0;
        drain();
        write_reg(tbrl_pkg::CFG_INTERVAL, 32'd1);
        write_reg(tbrl_pkg::CFG_QUANTUM, 32'd1);
        write_reg(tbrl_pkg::CFG_CAPACITY, '0);
        // walk the balance down with full-size takes
        for (i = 0; i < DEBT_STEPS; i++)
            send_item(tbrl_pkg::REQ_TAKE, '1, '0, 1'b1);
        send_item(tbrl_pkg::REQ_TAKE, 32'd1, '0, 1'b1);
        // too long a wait: refuse and keep the balance
        send_item(tbrl_pkg::REQ_TAKE, 32'd1, 63'd5, 1'b0);
        send_item(tbrl_pkg::REQ_AVAIL, 32'd5, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TIME, '0, '0, 1'b0);
        send_item(tbrl_pkg::REQ_TAKE, 32'd2, tbrl_pkg::WAIT_MAX, 1'b0);
        drain();
        write_reg(tbrl_pkg::CFG_INTERVAL, '1);
        send_item(tbrl_pkg::REQ_TAKE, 32'd2, '0, 1'b1);
        drain();
        idling_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned     sent;
        int unsigned     phase_no;
        int unsigned     n;
        int unsigned     roll;
        logic [tbrl_pkg::REQ_W-1:0]   kind;
        logic [tbrl_pkg::COUNT_W-1:0] tokens;
        logic [tbrl_pkg::WAIT_W-1:0]  patience;
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            idling_on = (phase_no % 5 != 2);
            if (phase_no == 0 || $urandom_range(99) < 70)
            begin
                roll = $urandom_range(99);
                write_reg(tbrl_pkg::CFG_INTERVAL, roll < 10 ? 32'd0 : roll < 35 ? 32'd1 :
                          roll < 75 ? 32'($urandom_range(8, 2)) :
                          roll < 95 ? 32'($urandom_range(100, 9)) : 32'($urandom));
            end
            if (phase_no == 0 || $urandom_range(99) < 70)
            begin
                roll = $urandom_range(99);
                write_reg(tbrl_pkg::CFG_QUANTUM, roll < 10 ? 32'd0 :
                          roll < 50 ? 32'($urandom_range(4, 1)) :
                          roll < 80 ? 32'($urandom_range(64, 5)) : 32'($urandom));
            end
            if (phase_no == 0 || $urandom_range(99) < 70)
            begin
                roll = $urandom_range(99);
                write_reg(tbrl_pkg::CFG_CAPACITY, roll < 5 ? 32'd0 :
                          roll < 55 ? 32'($urandom_range(32, 1)) :
                          roll < 85 ? 32'($urandom_range(1000, 33)) : 32'($urandom));
            end
            if ($urandom_range(99) < 10)
                write_reg(CFG_UNUSED, $urandom);
            n = $urandom_range(120, 40);
            repeat (n)
            begin
                if ($urandom_range(99) < 2)
                    hold_until_answered();
                roll = $urandom_range(99);
                kind = roll < 40 ? tbrl_pkg::REQ_TIME : roll < 70 ? tbrl_pkg::REQ_TAKE :
                       roll < 94 ? tbrl_pkg::REQ_AVAIL : REQ_UNUSED;
                roll = $urandom_range(99);
                tokens = roll < 5 ? '0 : roll < 10 ? '1 :
                         roll < 55 ? tbrl_pkg::COUNT_W'($urandom_range(8, 1)) :
                         roll < 85 ? tbrl_pkg::COUNT_W'($urandom_range(capacity_setting + 1, 1)) :
                         tbrl_pkg::COUNT_W'($urandom);
                roll = $urandom_range(99);
                patience = roll < 25 ? '0 :
                           roll < 60 ? tbrl_pkg::WAIT_W'($urandom_range(64, 0)) :
                           roll < 80 ? tbrl_pkg::WAIT_W'($urandom_range(100000, 0)) :
                           roll < 95 ? tbrl_pkg::WAIT_W'({$urandom, $urandom}) :
                           tbrl_pkg::WAIT_MAX;
                send_item(kind, tokens, patience, $urandom_range(99) < 30);
                sent++;
            end
            phase_no++;
        end
        idling_on = 1'b1;
    endtask

    always @(posedge clk)
    begin : drive_rsp_ready
        if (rsp_hold == 0 && idling_on && $urandom_range(99) < 30)
            rsp_hold = gap_length();
        if (rsp_hold != 0)
        begin
            rsp.ready <= 1'b0;
            rsp_hold--;
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        bucket_result_t due;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (bucket_results_due.size() == 0)
            begin
                $error("unexpected result transfer, balance %0h", rsp.balance);
                errors++;
            end
            else
            begin
                due = bucket_results_due.pop_front();
                if (rsp.status !== due.status)
                begin
                    $error("status: expected %0d, actual %0d", due.status, rsp.status);
                    errors++;
                end
                if (rsp.granted !== due.granted)
                begin
                    $error("granted: expected %0d, actual %0d", due.granted, rsp.granted);
                    errors++;
                end
                if (rsp.wait_time !== due.wait_time)
                begin
                    $error("wait_time: expected %0d, actual %0d", due.wait_time, rsp.wait_time);
                    errors++;
                end
                if (rsp.balance !== due.balance)
                begin
                    $error("balance: expected %0h, actual %0h", due.balance, rsp.balance);
                    errors++;
                end
                if (due.status == tbrl_pkg::STATUS_WAIT)
                    wait_refusals++;
                if (due.status == tbrl_pkg::STATUS_DEBT)
                    debt_refusals++;
                if (due.granted != 0)
                    grants++;
                results_checked++;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= tbrl_pkg::CFG_INTERVAL;
        cfg_data           <= '0;
        req.valid          <= 1'b0;
        req.req_type       <= tbrl_pkg::REQ_TIME;
        req.count          <= '0;
        req.max_wait       <= '0;
        req.wait_unlimited <= 1'b0;
        interval_setting = 32'd1;
        quantum_setting  = 32'd1;
        capacity_setting = 32'd1;
        level            = 1;
        tick_phase       = '0;
        idling_on        = 1'b1;
        rsp_hold         = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_zero_and_unused();
        test_register_extremes();
        test_phase_past_interval();
        test_wait_saturation();
        test_deep_debt();
        test_random_traffic();
        drain();

        $display("sent %0d time, %0d take, %0d take-available, %0d unused items; %0d reg writes",
                 kind_tally[tbrl_pkg::REQ_TIME], kind_tally[tbrl_pkg::REQ_TAKE],
                 kind_tally[tbrl_pkg::REQ_AVAIL], kind_tally[REQ_UNUSED], reg_writes);
        $display("checked %0d results: %0d wait refusals, %0d debt refusals, %0d grants",
                 results_checked, wait_refusals, debt_refusals, grants);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
